// ----- rtl/hbts_pkg.sv -----
// Shared widths, register indexes and helper functions for the height blend splat block.
`timescale 1ns / 1ps

package hbts_pkg;

  localparam int H_W     = 24;  // Q16.8 height
  localparam int TI_W    = 3;   // tile index field
  localparam int TC_W    = 4;   // tile count register
  localparam int CLR_W   = 8;   // colour channel
  localparam int OUT_W   = 17;  // Q1.16 result, 0..65536
  localparam int CACC_W  = 32;  // colour accumulators
  localparam int WACC_W  = 21;  // weight accumulator
  localparam int PROD_W  = OUT_W + CLR_W;
  localparam int BND_W   = 20;  // integer region bound
  localparam int CALC_W  = 29;  // bound times 256 plus span, signed
  localparam int DIV_W   = 29;  // divisor and partial remainder
  localparam int NUM_W   = 25;  // height difference, span, dividend shift bits
  localparam int CNT_W   = 5;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COUNT = 2'd2;

  localparam logic signed [H_W-1:0] MIN_HEIGHT_RST = 24'sd0;
  localparam logic signed [H_W-1:0] MAX_HEIGHT_RST = 24'sd65280;
  localparam logic [TC_W-1:0]       TILE_COUNT_RST = 4'd4;

  localparam logic [OUT_W-1:0] FULL_Q16 = 17'd65536;

  // Ramp and blend divisions yield 17 quotient bits, the span division all 25.
  localparam logic [CNT_W-1:0] QUO_STEPS  = CNT_W'(OUT_W);
  localparam logic [CNT_W-1:0] SPAN_STEPS = CNT_W'(NUM_W);

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  // Next region bound: (prev*256 + span) / 256, truncated toward zero.
  function automatic logic signed [BND_W-1:0] bound_step(
    input logic signed [BND_W-1:0] prev,
    input logic signed [NUM_W-1:0] span
  );
    logic signed [CALC_W-1:0] s;
    logic signed [CALC_W-1:0] q;
    s = CALC_W'($signed({prev, 8'h00})) + CALC_W'(span);
    q = s >>> 8;
    if (s[CALC_W-1] && (s[7:0] != 8'h00)) begin
      q = q + CALC_W'(1);
    end
    return BND_W'(q);
  endfunction

  // Colour accumulator plus weight times colour, saturating at full scale.
  function automatic logic [CACC_W-1:0] cacc_add(
    input logic [CACC_W-1:0] acc,
    input logic [OUT_W-1:0]  w,
    input logic [CLR_W-1:0]  c
  );
    logic [PROD_W-1:0] p;
    logic [CACC_W:0]   s;
    p = PROD_W'(w) * PROD_W'(c);
    s = (CACC_W + 1)'(acc) + (CACC_W + 1)'(p);
    return s[CACC_W] ? {CACC_W{1'b1}} : s[CACC_W-1:0];
  endfunction

endpackage

// ----- rtl/height_blend_texture_splat_top.sv -----
// Top level: region builder, shared restoring divider and blend sequencer.
`timescale 1ns / 1ps

// An item with weight passes through a setup step, a division in the shared restoring
// divider and an accumulate step before input ready returns; an item with zero weight or
// an unused tile skips the division. A last item then adds up to three blend divisions
// through the same divider, one per channel that does not saturate, plus setup and output.
// After reset and after each register write the bounds are rebuilt with input ready low;
// reset clears the accumulators to zero, a register write leaves them as they are.
module height_blend_texture_splat_top
  import hbts_pkg::*;
#(
  parameter int MAX_TILES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [H_W-1:0] height_i,
  input  logic [TI_W-1:0]      tile_index_i,
  input  logic [CLR_W-1:0]     red_in_i,
  input  logic [CLR_W-1:0]     green_in_i,
  input  logic [CLR_W-1:0]     blue_in_i,
  input  logic                 last_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_W-1:0]     red_out_o,
  output logic [OUT_W-1:0]     green_out_o,
  output logic [OUT_W-1:0]     blue_out_o
);

  localparam int TIW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int NTW = $clog2(MAX_TILES + 1);

  typedef enum logic [3:0] {
    S_SPAN_INIT,
    S_SPAN_DIV,
    S_BOUNDS,
    S_IDLE,
    S_WSETUP,
    S_WDIV,
    S_ACC,
    S_OSETUP,
    S_OLOAD,
    S_ODIV,
    S_PUSH
  } state_e;

  state_e state_q;

  // Configuration and control.
  logic signed [H_W-1:0] min_height_q, max_height_q;
  logic [TC_W-1:0]       tile_count_q;
  logic [TIW-1:0]        tile_q;
  chan_e                 ch_q;
  logic [CNT_W-1:0]      div_cnt_q;
  logic [CACC_W-1:0]     red_acc_q, green_acc_q, blue_acc_q;
  logic [WACC_W-1:0]     weight_acc_q;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_red_q, out_green_q, out_blue_q;

  // Datapath.
  logic signed [BND_W-1:0] low_arr [MAX_TILES];
  logic signed [BND_W-1:0] opt_arr [MAX_TILES];
  logic signed [BND_W-1:0] high_arr [MAX_TILES];
  logic signed [NUM_W-1:0] span_q;
  logic                    span_neg_q;
  logic signed [BND_W-1:0] prev_q;
  logic signed [H_W-1:0]   it_h_q;
  logic                    it_use_q;
  logic [CLR_W-1:0]        it_red_q, it_green_q, it_blue_q;
  logic                    it_last_q;
  logic signed [BND_W-1:0] b_low_q, b_opt_q, b_high_q;
  logic [OUT_W-1:0]        w_q;
  logic [DIV_W-1:0]        wd_q;
  logic [OUT_W-1:0]        res_red_q, res_green_q, res_blue_q;
  logic [DIV_W-1:0]        div_rem_q, div_d_q;
  logic [NUM_W-1:0]        div_num_q, div_quo_q;

  // Effective tile count.
  logic [NTW-1:0] n_eff;
  always_comb begin
    if (tile_count_q == '0) begin
      n_eff = NTW'(1);
    end else if (int'(tile_count_q) > MAX_TILES) begin
      n_eff = NTW'(MAX_TILES);
    end else begin
      n_eff = NTW'(tile_count_q);
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_MIN_HEIGHT || cfg_idx_i == CFG_MAX_HEIGHT ||
                                cfg_idx_i == CFG_TILE_COUNT);

  // Height span, split into sign and magnitude for the divider.
  logic signed [NUM_W-1:0] diff;
  logic [NUM_W-1:0]        diff_mag;
  assign diff     = NUM_W'(max_height_q) - NUM_W'(min_height_q);
  assign diff_mag = diff[NUM_W-1] ? NUM_W'(-diff) : NUM_W'(diff);

  logic signed [BND_W-1:0] opt_nx, high_nx;
  assign opt_nx  = bound_step(prev_q, span_q);
  assign high_nx = bound_step(opt_nx, span_q);

  logic tile_done;
  assign tile_done = (int'(tile_q) + 1) == int'(n_eff);

  logic [TIW-1:0] in_tidx;
  logic           in_use;
  assign in_tidx = TIW'(tile_index_i);
  assign in_use  = int'(tile_index_i) < int'(n_eff);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // Ramp setup: pick the rising or falling side and its numerator and width.
  logic signed [CALC_W-1:0] hs, lo, op, hi, d_up, a_up, d_dn, a_dn;
  logic                     w_zero;
  logic [DIV_W-1:0]         w_a, w_d;
  always_comb begin
    hs   = CALC_W'(it_h_q);
    lo   = CALC_W'($signed({b_low_q, 8'h00}));
    op   = CALC_W'($signed({b_opt_q, 8'h00}));
    hi   = CALC_W'($signed({b_high_q, 8'h00}));
    d_up = op - lo;
    a_up = hs - lo;
    d_dn = hi - op;
    a_dn = hi - hs;
    w_zero = 1'b0;
    w_a    = DIV_W'(a_up);
    w_d    = DIV_W'(d_up);
    if (!it_use_q || hs > hi || hs < lo) begin
      w_zero = 1'b1;
    end else if (hs < op) begin
      w_zero = d_up[CALC_W-1] || (d_up == CALC_W'(0));
    end else begin
      w_zero = d_dn[CALC_W-1] || (d_dn == CALC_W'(0));
      w_a    = DIV_W'(a_dn);
      w_d    = DIV_W'(d_dn);
    end
  end

  // Blend channel select and the saturation check before dividing.
  logic [CACC_W-1:0] ch_acc;
  logic              ch_ovf;
  logic              ch_last;
  always_comb begin
    unique case (ch_q)
      CH_RED:   ch_acc = red_acc_q;
      CH_GREEN: ch_acc = green_acc_q;
      CH_BLUE:  ch_acc = blue_acc_q;
      default:  ch_acc = '0;
    endcase
  end
  // The quotient overflows 17 bits exactly when acc/2 is not below the divisor.
  assign ch_ovf  = {1'b0, ch_acc[CACC_W-1:1]} >= CACC_W'(wd_q);
  assign ch_last = (ch_q == CH_BLUE);

  logic [OUT_W-1:0] quo_res, quo_clamped;
  assign quo_res     = div_quo_q[OUT_W-1:0];
  assign quo_clamped = (quo_res > FULL_Q16) ? FULL_Q16 : quo_res;

  // One restoring step of the shared divider.
  logic [DIV_W:0]   div_trial;
  logic             div_ge;
  logic [DIV_W-1:0] div_rem_nx;
  assign div_trial  = {div_rem_q, div_num_q[NUM_W-1]};
  assign div_ge     = div_trial >= {1'b0, div_d_q};
  assign div_rem_nx = div_ge ? DIV_W'(div_trial - {1'b0, div_d_q}) : DIV_W'(div_trial);

  logic [WACC_W:0]  wsum;
  logic [WACC_W-1:0] wacc_nx;
  assign wsum    = (WACC_W + 1)'(weight_acc_q) + (WACC_W + 1)'(w_q);
  assign wacc_nx = wsum[WACC_W] ? {WACC_W{1'b1}} : wsum[WACC_W-1:0];

  logic push_go;
  assign push_go = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);

  // Sequencer, configuration, accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SPAN_INIT;
      min_height_q <= MIN_HEIGHT_RST;
      max_height_q <= MAX_HEIGHT_RST;
      tile_count_q <= TILE_COUNT_RST;
      tile_q       <= '0;
      ch_q         <= CH_RED;
      div_cnt_q    <= '0;
      red_acc_q    <= '0;
      green_acc_q  <= '0;
      blue_acc_q   <= '0;
      weight_acc_q <= '0;
      out_valid_q  <= 1'b0;
      out_red_q    <= '0;
      out_green_q  <= '0;
      out_blue_q   <= '0;
    end else begin
      if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - CNT_W'(1);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_SPAN_INIT: begin
          div_cnt_q <= SPAN_STEPS;
          state_q   <= S_SPAN_DIV;
        end
        S_SPAN_DIV: begin
          if (div_cnt_q == '0) begin
            tile_q  <= '0;
            state_q <= S_BOUNDS;
          end
        end
        S_BOUNDS: begin
          tile_q <= tile_q + TIW'(1);
          if (tile_done) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_WSETUP;
          end
        end
        S_WSETUP: begin
          if (w_zero) begin
            state_q <= S_ACC;
          end else begin
            div_cnt_q <= QUO_STEPS;
            state_q   <= S_WDIV;
          end
        end
        S_WDIV: begin
          if (div_cnt_q == '0) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          weight_acc_q <= wacc_nx;
          red_acc_q    <= cacc_add(red_acc_q, w_q, it_red_q);
          green_acc_q  <= cacc_add(green_acc_q, w_q, it_green_q);
          blue_acc_q   <= cacc_add(blue_acc_q, w_q, it_blue_q);
          state_q      <= it_last_q ? S_OSETUP : S_IDLE;
        end
        S_OSETUP: begin
          ch_q    <= CH_RED;
          state_q <= (weight_acc_q == '0) ? S_PUSH : S_OLOAD;
        end
        S_OLOAD: begin
          if (!ch_ovf) begin
            div_cnt_q <= QUO_STEPS;
            state_q   <= S_ODIV;
          end else if (ch_last) begin
            state_q <= S_PUSH;
          end else begin
            ch_q <= chan_e'(ch_q + 2'd1);
          end
        end
        S_ODIV: begin
          if (div_cnt_q == '0) begin
            if (ch_last) begin
              state_q <= S_PUSH;
            end else begin
              ch_q    <= chan_e'(ch_q + 2'd1);
              state_q <= S_OLOAD;
            end
          end
        end
        S_PUSH: begin
          if (push_go) begin
            out_valid_q  <= 1'b1;
            out_red_q    <= res_red_q;
            out_green_q  <= res_green_q;
            out_blue_q   <= res_blue_q;
            red_acc_q    <= '0;
            green_acc_q  <= '0;
            blue_acc_q   <= '0;
            weight_acc_q <= '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_HEIGHT: min_height_q <= $signed(cfg_wdata_i[H_W-1:0]);
          CFG_MAX_HEIGHT: max_height_q <= $signed(cfg_wdata_i[H_W-1:0]);
          CFG_TILE_COUNT: tile_count_q <= cfg_wdata_i[TC_W-1:0];
          default: ;
        endcase
      end
      // A register write rebuilds the region bounds from scratch.
      if (cfg_hit) begin
        state_q <= S_SPAN_INIT;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (div_cnt_q != '0) begin
      div_rem_q <= div_rem_nx;
      div_num_q <= div_num_q << 1;
      div_quo_q <= {div_quo_q[NUM_W-2:0], div_ge};
    end

    unique case (state_q)
      S_SPAN_INIT: begin
        div_rem_q  <= '0;
        div_num_q  <= diff_mag;
        div_d_q    <= DIV_W'(n_eff);
        div_quo_q  <= '0;
        span_neg_q <= diff[NUM_W-1];
      end
      S_SPAN_DIV: begin
        span_q <= span_neg_q ? -$signed(div_quo_q) : $signed(div_quo_q);
        prev_q <= -BND_W'(1);
      end
      S_BOUNDS: begin
        low_arr[tile_q]  <= prev_q + BND_W'(1);
        opt_arr[tile_q]  <= opt_nx;
        high_arr[tile_q] <= high_nx;
        prev_q           <= opt_nx;
      end
      S_IDLE: begin
        if (in_acc) begin
          it_h_q     <= height_i;
          it_use_q   <= in_use;
          it_red_q   <= red_in_i;
          it_green_q <= green_in_i;
          it_blue_q  <= blue_in_i;
          it_last_q  <= last_i;
          b_low_q    <= low_arr[in_tidx];
          b_opt_q    <= opt_arr[in_tidx];
          b_high_q   <= high_arr[in_tidx];
        end
      end
      S_WSETUP: begin
        w_q <= '0;
        // Dividend is w_a * 65536; its top part starts as the partial remainder.
        div_rem_q <= DIV_W'(w_a[DIV_W-1:1]);
        div_num_q <= {w_a[0], 24'h000000};
        div_d_q   <= w_d;
        div_quo_q <= '0;
      end
      S_WDIV: begin
        if (div_cnt_q == '0) begin
          w_q <= quo_res;
        end
      end
      S_OSETUP: begin
        wd_q        <= DIV_W'({weight_acc_q, 8'h00}) - DIV_W'(weight_acc_q);
        res_red_q   <= '0;
        res_green_q <= '0;
        res_blue_q  <= '0;
      end
      S_OLOAD: begin
        div_rem_q <= DIV_W'(ch_acc[DIV_W:1]);
        div_num_q <= {ch_acc[0], 24'h000000};
        div_d_q   <= wd_q;
        div_quo_q <= '0;
        if (ch_ovf) begin
          unique case (ch_q)
            CH_RED:   res_red_q   <= FULL_Q16;
            CH_GREEN: res_green_q <= FULL_Q16;
            CH_BLUE:  res_blue_q  <= FULL_Q16;
            default: ;
          endcase
        end
      end
      S_ODIV: begin
        if (div_cnt_q == '0) begin
          unique case (ch_q)
            CH_RED:   res_red_q   <= quo_clamped;
            CH_GREEN: res_green_q <= quo_clamped;
            CH_BLUE:  res_blue_q  <= quo_clamped;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_red_q;
  assign green_out_o = out_green_q;
  assign blue_out_o  = out_blue_q;

  // Colour sums only grow together with the weight sum.
  a_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (weight_acc_q == '0) |-> (red_acc_q == '0 && green_acc_q == '0 && blue_acc_q == '0))
    else $error("colour accumulator nonzero with zero total weight");

  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_hit) |=> (state_q == S_WSETUP))
    else $error("accepted transaction did not enter ramp setup");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_out_o <= FULL_Q16 && green_out_o <= FULL_Q16 &&
                     blue_out_o <= FULL_Q16))
    else $error("blended colour above full scale");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SPAN_DIV || state_q == S_WDIV || state_q == S_ODIV) &&
     div_cnt_q != '0) |-> (div_d_q != '0))
    else $error("divider running with zero divisor");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (w_q <= FULL_Q16))
    else $error("ramp weight above one");

endmodule
